// ===== rtl/linear_probe_hash_table_core_macros.svh =====
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed (next cycle)");

`endif

// ===== rtl/lpht_pkg.sv =====
// Types, constants and helpers of the linear probing hash table.
`default_nettype none
package lpht_pkg;

    localparam int SLOTS      = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    // Unused code; behaves as a find.
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] old_value;
        logic [1:0]  status;
        logic [10:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        t_value      value;
    } t_slot;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_MOD
    } t_mix_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PRD,
        S_PCHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_FIN
    } t_state;

    function automatic t_idx next_slot(input t_idx i);
        return (i == IDX_W'(SLOTS - 1)) ? '0 : i + IDX_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lpht_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
`default_nettype none
module lpht_ram (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire lpht_pkg::t_idx   i_waddr,
    input  wire lpht_pkg::t_slot  i_wdata,
    input  wire lpht_pkg::t_idx   i_raddr,
    output lpht_pkg::t_slot       o_rdata
);

    lpht_pkg::t_slot r_mem [lpht_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lpht_mix.sv =====
// Multi-cycle splitmix64 finalizer and home slot reduction.
`default_nettype none
module lpht_mix (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [63:0]     i_key,
    output logic                 o_done,
    output lpht_pkg::t_idx       o_home
);

    localparam int REM_W = lpht_pkg::IDX_W + 4;

    lpht_pkg::t_mix_state r_state, n_state;
    logic [63:0]          r_x;
    logic [63:0]          r_acc;
    logic [1:0]           r_part;
    logic                 r_round;
    logic [3:0]           r_bits;
    lpht_pkg::t_idx       r_rem;

    logic [63:0]          konst;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          prod;
    logic [63:0]          y;
    logic [REM_W-1:0]     rem_acc;
    lpht_pkg::t_idx       rem_next;

    // One shared 32x32 multiplier; low 64 bits of the product come from three parts.
    assign konst = r_round ? lpht_pkg::MIX_C2 : lpht_pkg::MIX_C1;
    assign mul_a = (r_part == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mul_b = (r_part == 2'd1) ? konst[63:32] : konst[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign y     = r_acc ^ (r_acc >> 31);

    // Fold in one nibble a cycle; shifted compare and subtract keeps the remainder below SLOTS.
    always_comb begin
        rem_acc = {r_rem, r_x[63:60]};
        for (int b = 3; b >= 0; b--) begin
            if (rem_acc >= (REM_W'(lpht_pkg::SLOTS) << b)) begin
                rem_acc = rem_acc - (REM_W'(lpht_pkg::SLOTS) << b);
            end
        end
        rem_next = lpht_pkg::IDX_W'(rem_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpht_pkg::M_IDLE: begin
                if (i_start) n_state = lpht_pkg::M_MUL;
            end
            lpht_pkg::M_MUL: begin
                if (r_part == 2'd3 && r_round) begin
                    n_state = lpht_pkg::SLOTS_POW2 ? lpht_pkg::M_IDLE : lpht_pkg::M_MOD;
                end
            end
            lpht_pkg::M_MOD: begin
                if (r_bits == 4'd15) n_state = lpht_pkg::M_IDLE;
            end
            default: n_state = lpht_pkg::M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= ((r_state == lpht_pkg::M_MUL) && (r_part == 2'd3) && r_round &&
                       lpht_pkg::SLOTS_POW2) ||
                      ((r_state == lpht_pkg::M_MOD) && (r_bits == 4'd15));
            case (r_state)
                lpht_pkg::M_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_key ^ (i_key >> 30);
                        r_part  <= 2'd0;
                        r_round <= 1'b0;
                    end
                end
                lpht_pkg::M_MUL: begin
                    r_part <= r_part + 2'd1;
                    case (r_part) inside
                        2'd0: r_acc <= prod;
                        2'd1, 2'd2: r_acc <= r_acc + {prod[31:0], 32'h0};
                        default: begin
                            if (!r_round) begin
                                r_x     <= r_acc ^ (r_acc >> 27);
                                r_round <= 1'b1;
                            end else if (lpht_pkg::SLOTS_POW2) begin
                                o_home <= y[lpht_pkg::IDX_W-1:0];
                            end else begin
                                r_x    <= y;
                                r_rem  <= '0;
                                r_bits <= '0;
                            end
                        end
                    endcase
                end
                lpht_pkg::M_MOD: begin
                    r_rem  <= rem_next;
                    r_x    <= {r_x[59:0], 4'h0};
                    r_bits <= r_bits + 4'd1;
                    if (r_bits == 4'd15) begin
                        o_home <= rem_next;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/linear_probe_hash_table_core.sv =====
// Top level of the linear probing hash table with its operation sequencer.
//
//  channel | dir | handshake            | word
//  in      | in  | i_in_valid/o_in_stall | i_in_word  (kind, key, value)
//  out     | out | o_out_valid/i_out_stall| o_out_word (hit, old_value, status, entry_count)
//
// Steps: the key is hashed (with a remainder pass for a slot count that is not
// a power of two), then each visited slot is read through the registered
// memory read and checked, then the result is handed over. A remove also reads
// every entry that follows in its cluster and gives it a fresh hash and probe.
// Reset: a clearing pass over all SLOTS slots wipes the valid bits, with the
// input stalled. Output stall only delays the handover; the next word is taken
// while a result waits in the output register.
`default_nettype none
module linear_probe_hash_table_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire lpht_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output lpht_pkg::t_out_word       o_out_word
);

    lpht_pkg::t_state r_state, n_state;

    // Request and sequencer registers.
    logic [1:0]        r_kind;
    logic [63:0]       r_key;
    lpht_pkg::t_value  r_value;
    lpht_pkg::t_idx    r_pos;
    lpht_pkg::t_cnt    r_n;
    logic              r_reins;
    logic [63:0]       r_tk;
    lpht_pkg::t_value  r_tv;
    lpht_pkg::t_idx    r_walk;
    lpht_pkg::t_cnt    r_wn;
    lpht_pkg::t_cnt    r_count;
    logic              r_hit;
    logic [31:0]       r_old;
    logic [1:0]        r_status;
    logic              r_out_valid;
    lpht_pkg::t_out_word r_out;

    // Memory and hash unit wiring.
    logic              mem_we;
    lpht_pkg::t_idx    mem_waddr;
    lpht_pkg::t_slot   mem_wdata;
    lpht_pkg::t_idx    mem_raddr;
    lpht_pkg::t_slot   rd;
    logic              mix_start;
    logic [63:0]       mix_key;
    logic              mix_done;
    lpht_pkg::t_idx    mix_home;
    logic [63:0]       pkey;
    logic              accept;
    logic              out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pkey     = r_reins ? r_tk : r_key;
    assign mix_key  = (r_state == lpht_pkg::S_IDLE) ? i_in_word.key : rd.key;

    assign o_in_stall  = (r_state != lpht_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    lpht_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    lpht_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_key   (mix_key),
        .o_done  (mix_done),
        .o_home  (mix_home)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, memory port and hash start.
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = '{valid: 1'b0, key: r_key, value: r_value};
        mem_raddr = r_pos;
        mix_start = 1'b0;
        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_pos == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1)) n_state = lpht_pkg::S_IDLE;
            end
            lpht_pkg::S_IDLE: begin
                if (accept) begin
                    mix_start = 1'b1;
                    n_state   = lpht_pkg::S_HASH;
                end
            end
            lpht_pkg::S_HASH: begin
                if (mix_done) n_state = lpht_pkg::S_PRD;
            end
            lpht_pkg::S_PRD: begin
                n_state = lpht_pkg::S_PCHK;
            end
            lpht_pkg::S_PCHK: begin
                if (rd.valid && rd.key != pkey &&
                    r_n != lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1)) begin
                    n_state = lpht_pkg::S_PRD;
                end else if (r_reins) begin
                    // Place the moved entry again unless the probe came back full.
                    mem_we    = !(rd.valid && rd.key != pkey);
                    mem_wdata = '{valid: 1'b1, key: r_tk, value: r_tv};
                    n_state   = lpht_pkg::S_WALK_RD;
                end else if (rd.valid && rd.key == pkey) begin
                    if (r_kind == lpht_pkg::KIND_INSERT) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{valid: 1'b1, key: r_key, value: r_value};
                        n_state   = lpht_pkg::S_FIN;
                    end else if (r_kind == lpht_pkg::KIND_REMOVE) begin
                        mem_we  = 1'b1;
                        n_state = lpht_pkg::S_WALK_RD;
                    end else begin
                        n_state = lpht_pkg::S_FIN;
                    end
                end else begin
                    if (r_kind == lpht_pkg::KIND_INSERT && !rd.valid) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{valid: 1'b1, key: r_key, value: r_value};
                    end
                    n_state = lpht_pkg::S_FIN;
                end
            end
            lpht_pkg::S_WALK_RD: begin
                mem_raddr = r_walk;
                n_state   = (r_wn == lpht_pkg::CNT_W'(lpht_pkg::SLOTS))
                          ? lpht_pkg::S_FIN : lpht_pkg::S_WALK_CHK;
            end
            lpht_pkg::S_WALK_CHK: begin
                if (!rd.valid) begin
                    n_state = lpht_pkg::S_FIN;
                end else begin
                    // Take the entry out and rehash it.
                    mem_we    = 1'b1;
                    mem_waddr = r_walk;
                    mix_start = 1'b1;
                    n_state   = lpht_pkg::S_HASH;
                end
            end
            lpht_pkg::S_FIN: begin
                if (out_free) n_state = lpht_pkg::S_IDLE;
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_reins     <= 1'b0;
        end else begin
            // Load on handover, hold while stalled, drop once taken.
            r_out_valid <= ((r_state == lpht_pkg::S_FIN) && out_free) ||
                           (r_out_valid && i_out_stall);
            case (r_state)
                lpht_pkg::S_CLEAR: begin
                    r_pos <= r_pos + lpht_pkg::IDX_W'(1);
                end
                lpht_pkg::S_IDLE: begin
                    r_reins <= 1'b0;
                end
                lpht_pkg::S_HASH: begin
                    if (mix_done) begin
                        r_pos <= mix_home;
                        r_n   <= '0;
                    end
                end
                lpht_pkg::S_PCHK: begin
                    if (rd.valid && rd.key != pkey &&
                        r_n != lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1)) begin
                        r_n   <= r_n + lpht_pkg::CNT_W'(1);
                        r_pos <= lpht_pkg::next_slot(r_pos);
                    end else if (r_reins) begin
                        r_walk <= lpht_pkg::next_slot(r_walk);
                        r_wn   <= r_wn + lpht_pkg::CNT_W'(1);
                    end else if (rd.valid && rd.key == pkey) begin
                        if (r_kind == lpht_pkg::KIND_REMOVE) begin
                            r_count <= r_count - lpht_pkg::CNT_W'(1);
                            r_walk  <= lpht_pkg::next_slot(r_pos);
                            r_wn    <= lpht_pkg::CNT_W'(1);
                        end
                    end else if (r_kind == lpht_pkg::KIND_INSERT && !rd.valid) begin
                        r_count <= r_count + lpht_pkg::CNT_W'(1);
                    end
                end
                lpht_pkg::S_WALK_CHK: begin
                    r_reins <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_in_word.kind;
            r_key   <= i_in_word.key;
            r_value <= lpht_pkg::t_value'(64'(i_in_word.value));
        end
        if (r_state == lpht_pkg::S_PCHK && !r_reins &&
            !(rd.valid && rd.key != pkey &&
              r_n != lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1))) begin
            if (rd.valid && rd.key == pkey) begin
                r_hit    <= 1'b1;
                r_old    <= 32'(64'(rd.value));
                r_status <= lpht_pkg::STATUS_DONE;
            end else begin
                r_hit <= 1'b0;
                r_old <= '0;
                if (r_kind == lpht_pkg::KIND_INSERT) begin
                    r_status <= rd.valid ? lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_DONE;
                end else begin
                    r_status <= lpht_pkg::STATUS_NOTFOUND;
                end
            end
        end
        if (r_state == lpht_pkg::S_WALK_CHK) begin
            r_tk <= rd.key;
            r_tv <= rd.value;
        end
        if (r_state == lpht_pkg::S_FIN && out_free) begin
            r_out.hit         <= r_hit;
            r_out.old_value   <= r_old;
            r_out.status      <= r_status;
            r_out.entry_count <= 11'(r_count);
        end
    end

`include "linear_probe_hash_table_core_macros.svh"

    `LPHT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS))
    `LPHT_ASSERT_NEXT(a_accept_hash, i_clk, i_rst_n, accept, r_state == lpht_pkg::S_HASH)
    `LPHT_ASSERT_NEXT(a_fin_load, i_clk, i_rst_n, (r_state == lpht_pkg::S_FIN) && out_free, o_out_valid)
    `LPHT_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, r_state == lpht_pkg::S_IDLE, !mem_we)

endmodule
`default_nettype wire
